// ===== hdl/tbop_pkg.sv =====
// Shared types and constants for the timer bank.
`timescale 1ns / 1ps
package tbop_pkg;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  localparam logic [1:0] KIND_FIRED    = 2'd0;
  localparam logic [1:0] KIND_ADDED    = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] start;
    logic [30:0] timeout;
    logic        periodic;
  } entry_t;

  typedef struct packed {
    logic   fire;
    logic   keep;
    entry_t upd;
  } due_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage

// ===== hdl/timer_bank_oneshot_periodic_core.sv =====
// Timer bank top level: entry RAM, due check and list-walk sequencer.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+---------------------------
//  request   | in_op, in_now_ms, in_timeout_ms, in_periodic, | start & !busy
//            | in_tag                                        |
//  result    | out_kind, out_fired_tag, out_last             | out_valid, one cycle each
//
// An add is taken while idle and does not raise busy; its result follows in the next cycle.
// A tick walks the stored list through the due check, one entry per cycle from
// the RAM read port; busy stays high through the prime, walk and flush states,
// or through the flush state alone when the list is empty.
// Fired results leave during the walk; the final one appears in the same cycle that busy drops.
// Reset empties the list; the receiver cannot stall results.
`timescale 1ns / 1ps
module timer_bank_oneshot_periodic_core
  import tbop_pkg::*;
#(
  parameter int MAX_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_now_ms,
  input  logic [30:0] in_timeout_ms,
  input  logic        in_periodic,
  input  logic [7:0]  in_tag,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_fired_tag,
  output logic        out_last
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_TIMERS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] ev_idx_r, ev_idx_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [7:0]    pend_tag_r, pend_tag_nxt;
  logic [31:0]   now_r, now_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_tag_r, out_tag_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  entry_t        new_entry;
  due_t          due;
  logic          accept;
  logic          walk_end;

  tbop_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  tbop_due u_due (
    .entry  (ram_rdata),
    .now_ms (now_r),
    .due    (due)
  );

  assign busy          = (state_r != ST_IDLE);
  assign accept        = start && (state_r == ST_IDLE);
  assign walk_end      = (ev_idx_r == count_r - CW'(1));
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_fired_tag = out_tag_r;
  assign out_last      = out_last_r;

  always_comb begin
    new_entry.tag      = in_tag;
    new_entry.start    = in_now_ms;
    new_entry.timeout  = in_timeout_ms;
    new_entry.periodic = in_periodic;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_idx_nxt    = rd_idx_r;
    ev_idx_nxt    = ev_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_v_nxt    = pend_v_r;
    pend_tag_nxt  = pend_tag_r;
    now_nxt       = now_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_idx_r[IW-1:0];
    ram_wdata     = due.upd;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_ADD) begin
            out_valid_nxt = 1'b1;
            out_tag_nxt   = in_tag;
            out_last_nxt  = 1'b1;
            if (count_r != CNT_FULL) begin
              ram_we       = 1'b1;
              ram_waddr    = count_r[IW-1:0];
              ram_wdata    = new_entry;
              count_nxt    = count_r + CW'(1);
              out_kind_nxt = KIND_ADDED;
            end else begin
              out_kind_nxt = KIND_REJECTED;
            end
          end else begin
            now_nxt    = in_now_ms;
            rd_idx_nxt = '0;
            ev_idx_nxt = '0;
            wr_idx_nxt = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = (count_r == '0) ? ST_FLUSH : ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        rd_idx_nxt = rd_idx_r + IW'(1);
        state_nxt  = ST_WALK;
      end
      ST_WALK: begin
        rd_idx_nxt = rd_idx_r + IW'(1);
        ev_idx_nxt = ev_idx_r + CW'(1);
        if (due.keep) begin
          ram_we     = 1'b1;
          wr_idx_nxt = wr_idx_r + CW'(1);
        end
        if (due.fire) begin
          pend_v_nxt   = 1'b1;
          pend_tag_nxt = ram_rdata.tag;
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIRED;
            out_tag_nxt   = pend_tag_r;
            out_last_nxt  = 1'b0;
          end
        end
        if (walk_end) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        count_nxt = wr_idx_r;
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_tag_nxt   = pend_tag_r;
          out_last_nxt  = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    pend_tag_r <= pend_tag_nxt;
    now_r      <= now_nxt;
    out_kind_r <= out_kind_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== hdl/tbop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tbop_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tbop_due.sv =====
// Due check: elapsed-time compare and start update for one entry.
`timescale 1ns / 1ps
module tbop_due
  import tbop_pkg::*;
(
  input  entry_t      entry,
  input  logic [31:0] now_ms,
  output due_t        due
);

  logic [31:0] elapsed;

  always_comb begin
    elapsed       = now_ms - entry.start;
    due.fire      = (elapsed >= {1'b0, entry.timeout});
    due.keep      = !due.fire || entry.periodic;
    due.upd       = entry;
    due.upd.start = due.fire ? now_ms : entry.start;
  end

endmodule

// ===== test/timer_bank_oneshot_periodic_core_test.sv =====
// Self-checking testbench for the timer bank: add and tick requests with a predicted timer list.
`timescale 1ns / 1ps
module timer_bank_oneshot_periodic_core_test;
  import tbop_pkg::*;

  localparam int MAX_TIMERS = 16;
  localparam int RANDOM_REQUESTS = 400;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic [30:0] timeout_ms;
    logic        periodic;
    logic [7:0]  tag;
  } timer_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tag;
    logic       last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_op = OP_TICK;
  logic [31:0] in_now_ms = '0;
  logic [30:0] in_timeout_ms = '0;
  logic        in_periodic = 1'b0;
  logic [7:0]  in_tag = '0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_fired_tag;
  logic        out_last;

  timer_req_t    request_q[$];
  timer_result_t awaited_results[$];

  logic [7:0]  list_tag[MAX_TIMERS];
  logic [31:0] list_start[MAX_TIMERS];
  logic [30:0] list_timeout[MAX_TIMERS];
  logic        list_periodic[MAX_TIMERS];
  int          list_count = 0;

  int n_issued = 0;
  int n_accepted = 0;
  int gap_left = 0;
  int calm_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  timer_bank_oneshot_periodic_core #(
    .MAX_TIMERS(MAX_TIMERS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_now_ms(in_now_ms),
    .in_timeout_ms(in_timeout_ms),
    .in_periodic(in_periodic),
    .in_tag(in_tag),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_fired_tag(out_fired_tag),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic queue_request(input logic op, input logic [31:0] now_ms,
                               input logic [30:0] timeout_ms, input logic periodic,
                               input logic [7:0] tag);
    timer_req_t r;
    r.op = op;
    r.now_ms = now_ms;
    r.timeout_ms = timeout_ms;
    r.periodic = periodic;
    r.tag = tag;
    request_q = {request_q, r};
  endtask

  // Update the timer list for one accepted request and queue the results it causes.
  task automatic apply_request(input timer_req_t r);
    logic [7:0]    fired_tags[$];
    logic [31:0]   elapsed;
    timer_result_t res;
    int            i;
    if (r.op == OP_ADD) begin
      if (list_count < MAX_TIMERS) begin
        list_tag[list_count] = r.tag;
        list_start[list_count] = r.now_ms;
        list_timeout[list_count] = r.timeout_ms;
        list_periodic[list_count] = r.periodic;
        list_count++;
        res.kind = KIND_ADDED;
      end else begin
        res.kind = KIND_REJECTED;
      end
      res.tag = r.tag;
      res.last = 1'b1;
      awaited_results = {awaited_results, res};
    end else begin
      i = 0;
      while (i < list_count) begin
        elapsed = r.now_ms - list_start[i];
        if (elapsed >= {1'b0, list_timeout[i]}) begin
          list_start[i] = r.now_ms;
          fired_tags = {fired_tags, list_tag[i]};
          if (!list_periodic[i]) begin
            for (int j = i; j + 1 < list_count; j++) begin
              list_tag[j] = list_tag[j + 1];
              list_start[j] = list_start[j + 1];
              list_timeout[j] = list_timeout[j + 1];
              list_periodic[j] = list_periodic[j + 1];
            end
            list_count--;
            continue;
          end
        end
        i++;
      end
      for (int k = 0; k < fired_tags.size(); k++) begin
        res.kind = KIND_FIRED;
        res.tag = fired_tags[k];
        res.last = (k == fired_tags.size() - 1);
        awaited_results = {awaited_results, res};
      end
    end
  endtask

  // Hold the request until taken, then wait out the drawn gap.
  always @(negedge clk) begin
    timer_req_t r;
    if (rst_n && n_issued == n_accepted) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (request_q.size() != 0) begin
        r = request_q.pop_front();
        in_op <= r.op;
        in_now_ms <= r.now_ms;
        in_timeout_ms <= r.timeout_ms;
        in_periodic <= r.periodic;
        in_tag <= r.tag;
        start <= 1'b1;
        n_issued++;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          calm_left = $urandom_range(5, 25);
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    timer_req_t    r;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid) begin
        quiet_cycles = 0;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d tag=%0d last=%0b",
                                    out_kind, out_fired_tag, out_last));
        end else begin
          want = awaited_results.pop_front();
          if (out_kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", out_kind, want.kind));
          if (out_fired_tag !== want.tag)
            report_mismatch($sformatf("tag got %0d want %0d", out_fired_tag, want.tag));
          if (out_last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_last, want.last));
        end
      end
      if (start && !busy) begin
        quiet_cycles = 0;
        r.op = in_op;
        r.now_ms = in_now_ms;
        r.timeout_ms = in_timeout_ms;
        r.periodic = in_periodic;
        r.tag = in_tag;
        apply_request(r);
        n_accepted++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] clock_ms;
    logic [30:0] tmo;
    int          pick;

    // empty list, then fill across the time wrap
    queue_request(OP_TICK, 32'h0000_0000, 31'h7FFF_FFFF, 1'b1, 8'hFF);
    queue_request(OP_ADD, 32'hFFFF_FFF0, 31'd0, 1'b1, 8'd0);
    queue_request(OP_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0, 8'd255);
    for (int k = 1; k <= 13; k++)
      queue_request(OP_ADD, 32'hFFFF_FFF0, 31'(10 * k), 1'b0, 8'(k));
    queue_request(OP_ADD, 32'hFFFF_FFF0, 31'd5, 1'b1, 8'd14);
    queue_request(OP_ADD, 32'h1234_5678, 31'd7, 1'b1, 8'hAA);
    queue_request(OP_TICK, 32'h0000_0010, 31'd0, 1'b0, 8'h00);
    queue_request(OP_TICK, 32'h0000_0100, 31'h5555_5555, 1'b0, 8'h55);
    queue_request(OP_TICK, 32'h7FFF_FFFF, 31'h2AAA_AAAA, 1'b1, 8'hAA);
    queue_request(OP_TICK, 32'h7FFF_FFFF, 31'd0, 1'b0, 8'h00);
    queue_request(OP_TICK, 32'h7FFF_FFFF, 31'd0, 1'b0, 8'h00);

    clock_ms = 32'hFFFF_F000;
    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0: tmo = '0;
          1: tmo = 31'($urandom());
          2: tmo = 31'h7FFF_FFFF;
          default: tmo = 31'($urandom_range(0, 150));
        endcase
        queue_request(OP_ADD, ($urandom_range(0, 9) == 0) ? $urandom() : clock_ms,
                      tmo, ($urandom_range(0, 29) == 0), 8'($urandom()));
      end else begin
        if ($urandom_range(0, 9) == 0)
          clock_ms = $urandom();
        else
          clock_ms = clock_ms + $urandom_range(0, 60);
        queue_request(OP_TICK, clock_ms, 31'($urandom()), 1'($urandom()), 8'($urandom()));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || n_issued != n_accepted) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (MAX_TIMERS + 4) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
